// File: rtl/core/fdc_pkg.sv
package fdc_pkg;

   // Width of each operand of the shared serial multiplier.
   localparam int MUL_W = 32;

   localparam int DEFAULT_SAMPLE_BITS = 24;

   // The exponential lookup resolves DB_TABLE_DEPTH steps per octave. The
   // depth is a power of two, so quantizing the octave fraction keeps its
   // top DB_TABLE_BITS bits.
   localparam int DB_TABLE_DEPTH = 1024;
   localparam int DB_TABLE_BITS  = $clog2(DB_TABLE_DEPTH);

   localparam logic signed [15:0] LEVEL_FLOOR = -16'sd25600;
   localparam logic [15:0]        LEVEL_BIAS  = 16'd25600;
   localparam logic [19:0]        GAIN_MAX    = 20'hFFFFF;
   localparam logic [19:0]        GAIN_UNITY  = 20'd65536;
   localparam logic [31:0]        DB_PER_OCTAVE_Q16 = 32'd394566;
   localparam logic [31:0]        OCTAVE_PER_DB_Q8  = 32'd10885;

   // 2^(2^-(k+1)) in Q1.30.
   localparam logic [30:0] EXP2_BITS [16] = '{
      31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
      31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
      31'd1075196443, 31'd1074468888, 31'd1074105294, 31'd1073923544,
      31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753181
   };

   typedef enum logic [2:0] {
      CSR_THRESHOLD = 3'd0,
      CSR_SLOPE     = 3'd1,
      CSR_ATTACK    = 3'd2,
      CSR_RELEASE   = 3'd3,
      CSR_MAKEUP    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic             start;
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [2*MUL_W-1:0] prod;
   } mul_rsp_type;

endpackage

// File: rtl/core/fdc_serial_mul.sv
module fdc_serial_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  fdc_pkg::mul_req_type mul_req,
   output fdc_pkg::mul_rsp_type mul_rsp
);
   import fdc_pkg::*;

   localparam int CW = $clog2(MUL_W);

   logic [2*MUL_W-1:0] acc_ff;
   logic [MUL_W-1:0]   a_ff;
   logic [MUL_W-1:0]   b_ff;
   logic [CW-1:0]      cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [MUL_W:0]     sum_in;

   // One multiplier bit per cycle: add the multiplicand into the upper half
   // and shift the whole accumulator right.
   assign sum_in = {1'b0, acc_ff[2*MUL_W-1:MUL_W]} + (b_ff[0] ? {1'b0, a_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (mul_req.start) begin
            acc_ff  <= '0;
            a_ff    <= mul_req.a;
            b_ff    <= mul_req.b;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            acc_ff <= {sum_in, acc_ff[MUL_W-1:1]};
            b_ff   <= b_ff >> 1;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(MUL_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign mul_rsp.busy = busy_ff;
   assign mul_rsp.done = done_ff;
   assign mul_rsp.prod = acc_ff;

endmodule

// File: rtl/core/feedforward_audio_compressor_core.sv
// The shared one-bit-per-cycle multiplier serves every product: 16 log2
// squaring steps (skipped for a zero sample), up to ten exponential steps
// and up to eight others. Throughput: one request at a time; the next
// request is taken once the current one leaves the datapath, even if its
// result waits.
// Synchronous active-high reset loads defaults, -100 dB envelope, unity gain, empty output.
module feedforward_audio_compressor_core #(
   parameter int SAMPLE_BITS = fdc_pkg::DEFAULT_SAMPLE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: sample_in [SAMPLE_BITS-1:0], zero fill above.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] req_tdata,
   // rsp_tdata: sample_out [SAMPLE_BITS-1:0], zero fill above.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] rsp_tdata,
   input  logic                                  csr_wen,
   input  fdc_pkg::csr_index_type                csr_index,
   input  logic [15:0]                           csr_wdata
);
   import fdc_pkg::*;

   localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int SW      = $clog2(SAMPLE_BITS);
   localparam logic [35:0] SAT_HI  = 36'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic [35:0] SAT_MAG = 36'(64'd1 << (SAMPLE_BITS - 1));

   // Each multiply is issued from one state and resumes at ret_ff once the
   // serial multiplier reports done.
   typedef enum logic [4:0] {
      ST_IDLE, ST_ALIGN, ST_SQ, ST_SQ_DONE, ST_MAG, ST_LVL,
      ST_ENV_A, ST_ENV_B, ST_ENV_DONE, ST_RED, ST_RED_DONE,
      ST_DB, ST_DB_DONE, ST_EXP, ST_EXP_DONE, ST_SHIFT_INIT, ST_SHIFT,
      ST_GAIN_A, ST_GAIN_B, ST_GAIN_DONE, ST_OUT, ST_OUT_DONE, ST_EMIT,
      ST_MWAIT
   } state_type;

   state_type state_ff, ret_ff;

   // Configuration registers.
   logic signed [14:0] thr_ff;
   logic [14:0]        slope_ff;
   logic [15:0]        att_ff;
   logic [15:0]        rel_ff;
   logic signed [13:0] mk_ff;

   // Running state kept across requests.
   logic signed [15:0] env_ff;
   logic [19:0]        gain_ff;

   // Per-request working registers.
   logic                   neg_ff;
   logic [SAMPLE_BITS-1:0] ax_ff;
   logic [SAMPLE_BITS-1:0] norm_ff;
   logic [SW-1:0]          shc_ff;
   logic [15:0]            m_ff;
   logic [15:0]            frac_ff;
   logic [3:0]             cnt_ff;
   logic signed [15:0]     level_ff;
   logic [15:0]            c_ff;
   logic [39:0]            sum_ff;
   logic signed [15:0]     gdb_ff;
   logic                   sneg_ff;
   logic [22:0]            u_ff;
   logic [30:0]            acc_ff;
   logic [5:0]             sh_ff;
   logic [19:0]            tgt_ff;
   logic [SAMPLE_BITS-1:0] res_ff;
   logic [SAMPLE_BITS-1:0] rsp_data_ff;
   logic                   rsp_valid_ff;

   mul_req_type mreq_ff;
   mul_rsp_type mul_rsp;
   logic [63:0] prod;

   fdc_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mreq_ff),
      .mul_rsp (mul_rsp)
   );

   assign prod = mul_rsp.prod;

   // Combinational helpers for the state in hand.
   logic signed [SAMPLE_BITS-1:0] x_in;
   logic [SAMPLE_BITS-1:0]        ax_in;
   logic [16:0]                   sq_in;
   logic [20:0]                   mag_in;
   logic [39:0]                   lm_in;
   logic [15:0]                   env_off;
   logic [15:0]                   level_off;
   logic signed [15:0]            thr_ext;
   logic [15:0]                   excess;
   logic [29:0]                   red_in;
   logic signed [16:0]            s_in;
   logic [16:0]                   s_abs;
   logic [31:0]                   t_in;
   logic [61:0]                   exp_in;
   logic [6:0]                    ui;
   logic [31:0]                   round_in;
   logic [39:0]                   smooth_in;
   logic [51:0]                   out_in;
   logic [35:0]                   r_in;
   logic                          exp_bit;

   assign x_in      = req_tdata[SAMPLE_BITS-1:0];
   assign ax_in     = x_in[SAMPLE_BITS-1] ? SAMPLE_BITS'(-x_in) : SAMPLE_BITS'(x_in);
   assign sq_in     = prod[31:15];
   assign mag_in    = (shc_ff == '0) ? 21'd0 : 21'({shc_ff, 16'd0}) - 21'(frac_ff);
   assign lm_in     = (prod[39:0] + 40'd8388608) >> 24;
   assign env_off   = 16'(env_ff + $signed(LEVEL_BIAS));
   assign level_off = 16'(level_ff + $signed(LEVEL_BIAS));
   assign thr_ext   = 16'(thr_ff);
   assign excess    = 16'(env_ff - thr_ext);
   assign red_in    = (prod[29:0] + 30'd16384) >> 15;
   assign s_in      = 17'(gdb_ff) + 17'(mk_ff);
   assign s_abs     = s_in[16] ? 17'(-s_in) : 17'(s_in);
   assign t_in      = sneg_ff ? 32'h4000_0000 - prod[31:0] : 32'h4000_0000 + prod[31:0];
   assign exp_in    = (prod[61:0] + 62'h2000_0000) >> 30;
   assign ui        = u_ff[22:16];
   assign round_in  = (32'(acc_ff) + 32'd1) >> 1;
   assign smooth_in = (sum_ff + prod[39:0] + 40'd32768) >> 16;
   assign out_in    = (prod[51:0] + 52'd32768) >> 16;
   assign r_in      = out_in[35:0];
   // Only the top DB_TABLE_BITS bits of the octave fraction take part.
   assign exp_bit   = u_ff[4'd15 - cnt_ff] && (32'(cnt_ff) < DB_TABLE_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ret_ff        <= ST_IDLE;
         thr_ff        <= -15'sd5120;
         slope_ff      <= 15'd24576;
         att_ff        <= 16'd65400;
         rel_ff        <= 16'd65522;
         mk_ff         <= 14'sd0;
         env_ff        <= LEVEL_FLOOR;
         gain_ff       <= GAIN_UNITY;
         rsp_valid_ff  <= 1'b0;
         mreq_ff.start <= 1'b0;
      end else begin
         mreq_ff.start <= 1'b0;
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_wen) begin
            case (csr_index)
               CSR_THRESHOLD: thr_ff   <= csr_wdata[14:0];
               CSR_SLOPE:     slope_ff <= csr_wdata[14:0];
               CSR_ATTACK:    att_ff   <= csr_wdata;
               CSR_RELEASE:   rel_ff   <= csr_wdata;
               CSR_MAKEUP:    mk_ff    <= csr_wdata[13:0];
               default: ;
            endcase
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  neg_ff  <= x_in[SAMPLE_BITS-1];
                  ax_ff   <= ax_in;
                  norm_ff <= ax_in;
                  shc_ff  <= '0;
                  frac_ff <= '0;
                  cnt_ff  <= '0;
                  if (ax_in == '0) begin
                     level_ff <= LEVEL_FLOOR;
                     state_ff <= ST_ENV_A;
                  end else begin
                     state_ff <= ST_ALIGN;
                  end
               end
            end
            // Left-align the magnitude; the shift count is the octave.
            ST_ALIGN: begin
               if (norm_ff[SAMPLE_BITS-1]) begin
                  m_ff     <= norm_ff[SAMPLE_BITS-1 -: 16];
                  state_ff <= ST_SQ;
               end else begin
                  norm_ff <= norm_ff << 1;
                  shc_ff  <= shc_ff + 1'b1;
               end
            end
            ST_SQ: begin
               mreq_ff  <= '{start: 1'b1, a: MUL_W'(m_ff), b: MUL_W'(m_ff)};
               ret_ff   <= ST_SQ_DONE;
               state_ff <= ST_MWAIT;
            end
            // Each squaring yields one more fraction bit of log2.
            ST_SQ_DONE: begin
               frac_ff <= {frac_ff[14:0], sq_in[16]};
               m_ff    <= sq_in[16] ? sq_in[16:1] : sq_in[15:0];
               cnt_ff  <= cnt_ff + 1'b1;
               state_ff <= (cnt_ff == 4'd15) ? ST_MAG : ST_SQ;
            end
            ST_MAG: begin
               mreq_ff  <= '{start: 1'b1, a: MUL_W'(mag_in), b: DB_PER_OCTAVE_Q16};
               ret_ff   <= ST_LVL;
               state_ff <= ST_MWAIT;
            end
            ST_LVL: begin
               level_ff <= (lm_in > 40'd25600) ? LEVEL_FLOOR : -$signed(16'(lm_in));
               state_ff <= ST_ENV_A;
            end
            ST_ENV_A: begin
               c_ff     <= (level_ff > env_ff) ? att_ff : rel_ff;
               mreq_ff  <= '{start: 1'b1,
                              a: MUL_W'((level_ff > env_ff) ? att_ff : rel_ff),
                              b: MUL_W'(env_off)};
               ret_ff   <= ST_ENV_B;
               state_ff <= ST_MWAIT;
            end
            ST_ENV_B: begin
               sum_ff   <= prod[39:0];
               mreq_ff  <= '{start: 1'b1, a: MUL_W'(17'd65536 - 17'(c_ff)),
                              b: MUL_W'(level_off)};
               ret_ff   <= ST_ENV_DONE;
               state_ff <= ST_MWAIT;
            end
            ST_ENV_DONE: begin
               env_ff   <= 16'(smooth_in) - $signed(LEVEL_BIAS);
               state_ff <= ST_RED;
            end
            ST_RED: begin
               if (env_ff > thr_ext) begin
                  mreq_ff  <= '{start: 1'b1, a: MUL_W'(excess), b: MUL_W'(slope_ff)};
                  ret_ff   <= ST_RED_DONE;
                  state_ff <= ST_MWAIT;
               end else begin
                  gdb_ff   <= '0;
                  state_ff <= ST_DB;
               end
            end
            ST_RED_DONE: begin
               gdb_ff   <= -$signed(16'(red_in));
               state_ff <= ST_DB;
            end
            ST_DB: begin
               sneg_ff  <= s_in[16];
               mreq_ff  <= '{start: 1'b1, a: MUL_W'(s_abs), b: OCTAVE_PER_DB_Q8};
               ret_ff   <= ST_DB_DONE;
               state_ff <= ST_MWAIT;
            end
            // Octave count offset by 64 in the upper bits, fraction below.
            ST_DB_DONE: begin
               u_ff     <= t_in[30:8];
               acc_ff   <= 31'h4000_0000;
               cnt_ff   <= '0;
               state_ff <= ST_EXP;
            end
            ST_EXP: begin
               if (exp_bit) begin
                  mreq_ff  <= '{start: 1'b1, a: MUL_W'(acc_ff),
                                 b: MUL_W'(EXP2_BITS[cnt_ff])};
                  ret_ff   <= ST_EXP_DONE;
                  state_ff <= ST_MWAIT;
               end else begin
                  cnt_ff   <= cnt_ff + 1'b1;
                  state_ff <= (cnt_ff == 4'd15) ? ST_SHIFT_INIT : ST_EXP;
               end
            end
            ST_EXP_DONE: begin
               acc_ff   <= exp_in[30:0];
               cnt_ff   <= cnt_ff + 1'b1;
               state_ff <= (cnt_ff == 4'd15) ? ST_SHIFT_INIT : ST_EXP;
            end
            // The Q1.30 mantissa moves to Q4.16 by a right shift of
            // 78 minus the offset octave count, one bit per cycle.
            ST_SHIFT_INIT: begin
               if (ui >= 7'd78) begin
                  tgt_ff   <= GAIN_MAX;
                  state_ff <= ST_GAIN_A;
               end else if (ui <= 7'd16) begin
                  tgt_ff   <= '0;
                  state_ff <= ST_GAIN_A;
               end else begin
                  sh_ff    <= 6'(7'd77 - ui);
                  state_ff <= ST_SHIFT;
               end
            end
            ST_SHIFT: begin
               if (sh_ff == '0) begin
                  tgt_ff   <= (round_in > 32'(GAIN_MAX)) ? GAIN_MAX : round_in[19:0];
                  state_ff <= ST_GAIN_A;
               end else begin
                  acc_ff <= acc_ff >> 1;
                  sh_ff  <= sh_ff - 1'b1;
               end
            end
            ST_GAIN_A: begin
               c_ff     <= (tgt_ff < gain_ff) ? att_ff : rel_ff;
               mreq_ff  <= '{start: 1'b1,
                              a: MUL_W'((tgt_ff < gain_ff) ? att_ff : rel_ff),
                              b: MUL_W'(gain_ff)};
               ret_ff   <= ST_GAIN_B;
               state_ff <= ST_MWAIT;
            end
            ST_GAIN_B: begin
               sum_ff   <= prod[39:0];
               mreq_ff  <= '{start: 1'b1, a: MUL_W'(17'd65536 - 17'(c_ff)),
                              b: MUL_W'(tgt_ff)};
               ret_ff   <= ST_GAIN_DONE;
               state_ff <= ST_MWAIT;
            end
            ST_GAIN_DONE: begin
               gain_ff  <= smooth_in[19:0];
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               mreq_ff  <= '{start: 1'b1, a: MUL_W'(ax_ff), b: MUL_W'(gain_ff)};
               ret_ff   <= ST_OUT_DONE;
               state_ff <= ST_MWAIT;
            end
            // Apply the sign and clamp to the signed sample range.
            ST_OUT_DONE: begin
               if (!neg_ff) begin
                  res_ff <= (r_in > SAT_HI) ? SAMPLE_BITS'(SAT_HI) : SAMPLE_BITS'(r_in);
               end else begin
                  res_ff <= (r_in > SAT_MAG) ? SAMPLE_BITS'(SAT_MAG)
                                             : SAMPLE_BITS'(-r_in);
               end
               state_ff <= ST_EMIT;
            end
            // Hand the result to the output register once it is free.
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_MWAIT: begin
               if (mul_rsp.done) begin
                  state_ff <= ret_ff;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_data_ff);

`ifndef SYNTHESIS
   a_env_range: assert property (@(posedge clock) disable iff (reset)
      (env_ff >= LEVEL_FLOOR) && (env_ff <= 16'sd0))
      else $error("envelope left its range");

   a_mul_idle_start: assert property (@(posedge clock) disable iff (reset)
      mreq_ff.start |-> !mul_rsp.busy)
      else $error("multiply issued while busy");

   a_accept_idle_mul: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !mul_rsp.busy)
      else $error("request taken during a multiply");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside emit");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
   import fdc_pkg::*;

   localparam int SB = DEFAULT_SAMPLE_BITS;
   localparam int DW = ((SB + 7) / 8) * 8;
   localparam int RANDOM_REQUESTS = 1300;
   localparam int IDLE_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [DW-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [DW-1:0] rsp_tdata;
   logic csr_wen = 1'b0;
   csr_index_type csr_index = CSR_THRESHOLD;
   logic [15:0] csr_wdata = '0;

   feedforward_audio_compressor_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Predictor copy of the control registers and the two pieces of state.
   longint thr_db, slope_q15, atk_c, rel_c, mkp_db;
   longint env_db, gain_q16;

   logic [SB-1:0] expected_samples[$];
   int errors = 0;
   bit long_hold = 1'b0;

   // Peak level of a sample magnitude, in 1/256 dB, floored at -100 dB.
   function automatic longint peak_level(longint unsigned a);
      int p;
      longint unsigned m, frac, lm;
      longint mag;
      if (a == 0) return -25600;
      p = 0;
      while (p < 62 && (a >> (p + 1)) != 0) p++;
      m = (p >= 15) ? (a >> (p - 15)) : (a << (15 - p));
      frac = 0;
      for (int k = 0; k < 16; k++) begin
         m = (m * m) >> 15;
         frac = frac << 1;
         if (m >= 65536) begin
            m = m >> 1;
            frac = frac | 1;
         end
      end
      mag = (longint'(SB - 1) - p) * 65536 - longint'(frac);
      if (mag < 0) mag = 0;
      lm = (longint'(mag) * 394566 + (64'd1 << 23)) >> 24;
      if (lm > 25600) return -25600;
      return -longint'(lm);
   endfunction

   // One-pole smoothing on values shifted to be nonnegative.
   function automatic longint one_pole(longint old, longint tgt, longint c, longint bias);
      longint unsigned o, t, r;
      o = old + bias;
      t = tgt + bias;
      r = (longint'(c) * o + (65536 - c) * t + 32768) >> 16;
      return longint'(r) - bias;
   endfunction

   // Gain in 1/256 dB to linear Q4.16 through the quantized exponential.
   function automatic longint gain_linear(longint gdb);
      longint t, ip, sh;
      longint unsigned u, frac, q, acc;
      t = gdb * 10885 + (longint'(64) << 24);
      if (t < 0) return 0;
      u = t >> 8;
      ip = longint'(u >> 16) - 64;
      frac = u & 16'hFFFF;
      q = (frac * DB_TABLE_DEPTH) >> 16;
      frac = (q << 16) / DB_TABLE_DEPTH;
      acc = 64'd1 << 30;
      for (int k = 0; k < 16; k++)
         if (frac & (64'h8000 >> k))
            acc = (acc * EXP2_BITS[k] + (64'd1 << 29)) >> 30;
      sh = 14 - ip;
      if (sh <= 0) return 64'hFFFFF;
      if (sh >= 62) return 0;
      u = (acc + (64'd1 << (sh - 1))) >> sh;
      if (u > 64'hFFFFF) return 64'hFFFFF;
      return longint'(u);
   endfunction

   function automatic logic [SB-1:0] compress_sample(logic [SB-1:0] s);
      longint x, lvl, gdb, tgt, y;
      longint unsigned ax, r;
      x = longint'(signed'(s));
      ax = (x < 0) ? -x : x;
      lvl = peak_level(ax);
      if (lvl > env_db) env_db = one_pole(env_db, lvl, atk_c, 25600);
      else env_db = one_pole(env_db, lvl, rel_c, 25600);
      gdb = 0;
      if (env_db > thr_db) gdb = -longint'(((env_db - thr_db) * slope_q15 + 16384) >> 15);
      tgt = gain_linear(gdb + mkp_db);
      if (tgt < gain_q16) gain_q16 = one_pole(gain_q16, tgt, atk_c, 0);
      else gain_q16 = one_pole(gain_q16, tgt, rel_c, 0);
      r = (ax * gain_q16 + 32768) >> 16;
      if (r > (64'd1 << 40)) r = 64'd1 << 40;
      y = (x < 0) ? -longint'(r) : longint'(r);
      if (y > (longint'(1) << (SB - 1)) - 1) y = (longint'(1) << (SB - 1)) - 1;
      if (y < -(longint'(1) << (SB - 1))) y = -(longint'(1) << (SB - 1));
      return y[SB-1:0];
   endfunction

   // Registers are written only while the block holds no request.
   task automatic write_register(csr_index_type idx, logic [15:0] value);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_THRESHOLD: thr_db = longint'(signed'(value[14:0]));
         CSR_SLOPE: slope_q15 = value[14:0];
         CSR_ATTACK: atk_c = value;
         CSR_RELEASE: rel_c = value;
         CSR_MAKEUP: mkp_db = longint'(signed'(value[13:0]));
         default: ;
      endcase
   endtask

   // Offers one request; bursts leave req_tvalid high between requests.
   task automatic send_request(logic [SB-1:0] s, bit keep_valid);
      req_tvalid <= 1'b1;
      req_tdata <= DW'(s);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_samples.push_back(compress_sample(s));
      if (!keep_valid) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain();
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Directed rows: sample and, where obvious, the expected output.
   typedef struct {
      logic [SB-1:0] sample;
      bit            known;
      logic [SB-1:0] result;
   } directed_row_type;

   directed_row_type directed_rows[] = '{
      '{24'h000000, 1'b1, 24'h000000},
      '{24'h000001, 1'b1, 24'h000001},
      '{24'hFFFFFF, 1'b1, 24'hFFFFFF},
      '{24'h7FFFFF, 1'b0, 24'h0},
      '{24'h800000, 1'b0, 24'h0},
      '{24'h400000, 1'b0, 24'h0},
      '{24'hC00000, 1'b0, 24'h0},
      '{24'h000000, 1'b0, 24'h0},
      '{24'h555555, 1'b0, 24'h0},
      '{24'hAAAAAA, 1'b0, 24'h0},
      '{24'h7FFFFF, 1'b0, 24'h0},
      '{24'h800000, 1'b0, 24'h0}
   };

   // Receiver: a stall pattern of its own, plus one long hold-off.
   initial begin
      int hold;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            hold = 0;
            while (hold < 3000) begin
               @(posedge clock);
               hold++;
            end
            long_hold = 1'b0;
         end
         case ($urandom_range(0, 3))
            0: rsp_tready <= 1'b0;
            default: rsp_tready <= 1'b1;
         endcase
      end
   end

   // Result checker samples at the clock edge where the handshake completes.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, rsp_tdata[SB-1:0]);
            errors++;
         end else begin
            logic [SB-1:0] want;
            want = expected_samples.pop_front();
            if (rsp_tdata[SB-1:0] !== want) begin
               $display("%0t: sample_out expected %h actual %h", $time, want,
                        rsp_tdata[SB-1:0]);
               errors++;
            end
         end
      end
   end

   // Watchdog: counts cycles without any accepted request or result.
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      logic [SB-1:0] s;
      int burst;
      thr_db = -5120; slope_q15 = 24576; atk_c = 65400; rel_c = 65522; mkp_db = 0;
      env_db = -25600; gain_q16 = 65536;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at reset settings; the first rows come out unchanged.
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].sample, 1'b0);
         if (directed_rows[i].known) expected_samples[$] = directed_rows[i].result;
      end
      drain();

      // Phases of random traffic over several settings, extremes included.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_register(CSR_THRESHOLD, 16'h0000);
               write_register(CSR_MAKEUP, 16'(6144));
            end
            1: begin
               write_register(CSR_THRESHOLD, 16'(-15360));
               write_register(CSR_SLOPE, 16'd32767);
               write_register(CSR_ATTACK, 16'd0);
               write_register(CSR_RELEASE, 16'd0);
               write_register(CSR_MAKEUP, 16'(-6144));
            end
            2: begin
               write_register(CSR_SLOPE, 16'd0);
               write_register(CSR_ATTACK, 16'hFFFF);
               write_register(CSR_RELEASE, 16'hFFFF);
               write_register(CSR_MAKEUP, 16'(6144));
            end
            default: begin
               write_register(CSR_THRESHOLD, 16'(-$urandom_range(0, 15360)));
               write_register(CSR_SLOPE, 16'($urandom_range(0, 32767)));
               write_register(CSR_ATTACK, 16'($urandom_range(0, 65535)));
               write_register(CSR_RELEASE, 16'($urandom_range(0, 65535)));
               write_register(CSR_MAKEUP, 16'($urandom_range(0, 12288)) - 16'd6144);
               // An unknown index must leave every register as it was.
               @(posedge clock);
               csr_wen <= 1'b1;
               csr_index <= csr_index_type'(3'd7);
               csr_wdata <= 16'($urandom);
               @(posedge clock);
               csr_wen <= 1'b0;
            end
         endcase
         if (phase == 3) long_hold = 1'b1;
         for (int n = 0; n < RANDOM_REQUESTS / 6; n += burst) begin
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst; b++) begin
               case ($urandom_range(0, 5))
                  0: s = SB'($urandom_range(0, 255)) - SB'(128);
                  1: s = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                  2: s = SB'($urandom) >>> $urandom_range(0, 22);
                  default: s = SB'($urandom);
               endcase
               send_request(s, b != burst - 1);
            end
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0) @(posedge clock);
         end
         drain();
      end

      if (errors == 0 && expected_samples.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
